// File: rtl/gbw_pkg.sv
// Shared constants, kernel weights and register codes for the Gaussian blur window.
package gbw_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int Lines     = 4;
  localparam int WinSize   = 5;

  localparam int PixW    = 8;
  localparam int PosW    = 10;
  localparam int DimW    = 11;
  localparam int WeightW = 4;
  localparam int ProdW   = PixW + WeightW;
  localparam int RowSumW = 14;
  localparam int SumW    = 16;

  // floor(n / 159) == (n * Recip159) >> RecipShift for every n below 2^SumW
  localparam int RecipW               = 17;
  localparam logic [RecipW-1:0] Recip159 = 17'd105518;
  localparam int RecipShift           = 24;

  typedef logic [PixW-1:0] pix_t;

  typedef enum logic [1:0] {
    RegKernel = 2'd0,
    RegWidth  = 2'd1,
    RegHeight = 2'd2
  } reg_idx_e;

  localparam logic [WeightW-1:0] Gauss5 [5][5] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

  localparam logic [WeightW-1:0] Gauss3 [3][3] = '{
    '{4'd1, 4'd2, 4'd1},
    '{4'd2, 4'd4, 4'd2},
    '{4'd1, 4'd2, 4'd1}
  };

  // Weight of one window tap; the small kernel sits in the bottom-right corner.
  function automatic logic [WeightW-1:0] gauss_weight(input logic       ksel,
                                                      input logic [2:0] wr,
                                                      input logic [2:0] wc);
    logic [2:0]         sr;
    logic [2:0]         sc;
    logic [WeightW-1:0] w;
    sr = wr - 3'd2;
    sc = wc - 3'd2;
    if (ksel) begin
      w = Gauss5[wr][wc];
    end else if (wr >= 3'd2 && wc >= 3'd2) begin
      w = Gauss3[sr[1:0]][sc[1:0]];
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

// File: rtl/gbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbw_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read and write at one address return the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gbw_cell.sv
// One window tap: holds a pixel, weights it and passes the pixel on.
module gbw_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  gbw_pkg::pix_t               pix_i,
  input  logic [gbw_pkg::WeightW-1:0] weight_i,
  output gbw_pkg::pix_t               pix_o,
  output logic [gbw_pkg::ProdW-1:0]   prod_o
);
  import gbw_pkg::*;

  pix_t pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  // weight the held pixel with the weight of the kernel selected now
  assign pix_o  = pix_q;
  assign prod_o = ProdW'(weight_i) * ProdW'(pix_q);

endmodule

// File: rtl/gbw_window.sv
// 5x5 sliding window built from rows of shifting cells, with per-row weighted sums.
module gbw_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic                        kernel_sel_i,
  input  gbw_pkg::pix_t               col_i     [gbw_pkg::WinSize],
  output logic [gbw_pkg::RowSumW-1:0] row_sum_o [gbw_pkg::WinSize]
);
  import gbw_pkg::*;

  pix_t             tap_pix  [WinSize][WinSize];
  logic [ProdW-1:0] tap_prod [WinSize][WinSize];

  // column WinSize-1 takes the new column, the others take their right neighbor
  for (genvar gr = 0; gr < WinSize; gr++) begin : g_row
    for (genvar gc = 0; gc < WinSize; gc++) begin : g_col
      pix_t cell_in;
      if (gc == WinSize - 1) begin : g_edge
        assign cell_in = col_i[gr];
      end else begin : g_inner
        assign cell_in = tap_pix[gr][gc+1];
      end
      gbw_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (shift_i),
        .pix_i    (cell_in),
        .weight_i (gauss_weight(kernel_sel_i, 3'(gr), 3'(gc))),
        .pix_o    (tap_pix[gr][gc]),
        .prod_o   (tap_prod[gr][gc])
      );
    end
  end

  always_comb begin
    for (int r = 0; r < WinSize; r++) begin
      row_sum_o[r] = '0;
      for (int c = 0; c < WinSize; c++) begin
        row_sum_o[r] = row_sum_o[r] + RowSumW'(tap_prod[r][c]);
      end
    end
  end

endmodule

// File: rtl/gaussian_blur_window.sv
// Top level: position tracking, line stores, window pipeline, divide and register port.
// An accepted pixel passes stage 1, the window cells, row sums, full sum and output register.
// Throughput: one pixel per clock unless stalled; line stores read/write one column per cycle.
// Stall from the output ripples back only through full stages, so bubbles are absorbed.
// Reset: registers return to 3x3 kernel, 640x480; position, window and pipeline clear.
// Line stores are not cleared at reset; rows read before they are written are undefined.
module gaussian_blur_window (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // pixel input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [gbw_pkg::PixW-1:0] pixel_i,
  input  logic                     frame_start_i,
  // blurred output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [gbw_pkg::PixW-1:0] blurred_o,
  output logic [gbw_pkg::PosW-1:0] column_o,
  output logic [gbw_pkg::PosW-1:0] row_o,
  output logic                     last_o,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import gbw_pkg::*;

  localparam int AddrW = $clog2(MaxWidth);

  typedef struct packed {
    logic [PosW-1:0] cx;
    logic [PosW-1:0] cy;
    logic            last;
  } meta_t;

  // ---------------------------------------------------------------------------
  // Register port: always ready, write on the access phase.
  // ---------------------------------------------------------------------------
  logic            ksel_q;
  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q   <= 1'b0;
      width_q  <= 11'd640;
      height_q <= 11'd480;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegKernel: ksel_q   <= pwdata[0];
        RegWidth:  width_q  <= pwdata[DimW-1:0];
        RegHeight: height_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegKernel: prdata = {31'd0, ksel_q};
      RegWidth:  prdata = {{(32-DimW){1'b0}}, width_q};
      RegHeight: prdata = {{(32-DimW){1'b0}}, height_q};
      default:   prdata = '0;
    endcase
  end

  // Effective frame size: zero reads as one, oversize saturates at the store size.
  logic [DimW-1:0] w_eff;
  logic [DimW-1:0] h_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DimW'(1);
    end else if (width_q > DimW'(MaxWidth)) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DimW'(1);
    end else if (height_q > DimW'(MaxHeight)) begin
      h_eff = DimW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its word moves on.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic ld1, ld2, ld3, ld4, ldo;
  logic in_acc;

  assign ldo        = !vo_q || !out_stall_i;
  assign ld4        = !v4_q || ldo;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_stall_o = !ld1;
  assign in_acc     = in_valid_i && ld1;

  // ---------------------------------------------------------------------------
  // Position of the incoming pixel. Wrap counters that sit past the frame edge
  // (after a size change) before using them, then advance for the next pixel.
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] col_q, row_q;
  logic [PosW-1:0] c0, r0, c_cur, r_cur;
  logic [DimW-1:0] r_inc, c_nxt, r_nxt;
  logic            wrap_c, end_row;

  assign c0      = frame_start_i ? '0 : col_q;
  assign r0      = frame_start_i ? '0 : row_q;
  assign wrap_c  = {1'b0, c0} >= w_eff;
  assign r_inc   = {1'b0, r0} + (wrap_c ? DimW'(1) : DimW'(0));
  assign c_cur   = wrap_c ? '0 : c0;
  assign r_cur   = (r_inc >= h_eff) ? '0 : r_inc[PosW-1:0];
  assign c_nxt   = {1'b0, c_cur} + DimW'(1);
  assign r_nxt   = {1'b0, r_cur} + DimW'(1);
  assign end_row = c_nxt >= w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= end_row ? '0 : c_nxt[PosW-1:0];
      if (end_row) begin
        row_q <= (r_nxt >= h_eff) ? '0 : r_nxt[PosW-1:0];
      end else begin
        row_q <= r_cur;
      end
    end
  end

  // Output window: centre trails by half a kernel; keep centres k away from
  // every edge. half = 1 or 2, k + half = 4 or 7, k - half = 2 or 3,
  // k + 1 - half = 3 or 4.
  logic [DimW-1:0] k_lo, k_reach, k_span;
  logic [PosW-1:0] k_half;
  logic            emit_a, last_a;
  meta_t           meta_a;

  assign k_half  = ksel_q ? PosW'(2) : PosW'(1);
  assign k_lo    = ksel_q ? DimW'(7) : DimW'(4);
  assign k_reach = ksel_q ? DimW'(3) : DimW'(2);
  assign k_span  = ksel_q ? DimW'(4) : DimW'(3);

  assign emit_a = ({1'b0, c_cur} >= k_lo) && ({1'b0, c_cur} + k_reach < w_eff) &&
                  ({1'b0, r_cur} >= k_lo) && ({1'b0, r_cur} + k_reach < h_eff);
  assign last_a = ({1'b0, c_cur} + k_span == w_eff) && ({1'b0, r_cur} + k_span == h_eff);

  assign meta_a.cx   = c_cur - k_half;
  assign meta_a.cy   = r_cur - k_half;
  assign meta_a.last = last_a;

  // ---------------------------------------------------------------------------
  // Line stores: one RAM per stored row. Read all four at the column, write
  // the new pixel over the oldest row in the same cycle (read-first).
  // ---------------------------------------------------------------------------
  pix_t line_rd [Lines];

  for (genvar gl = 0; gl < Lines; gl++) begin : g_line
    gbw_ram #(
      .Width (PixW),
      .Depth (MaxWidth)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (in_acc && (r_cur[1:0] == 2'(gl))),
      .waddr_i (c_cur[AddrW-1:0]),
      .wdata_i (pixel_i),
      .re_i    (in_acc),
      .raddr_i (c_cur[AddrW-1:0]),
      .rdata_o (line_rd[gl])
    );
  end

  // Stage 1: pixel and position wait for the line store read.
  pix_t       px1_q;
  logic [1:0] line1_q;
  logic       emit1_q;
  meta_t      meta1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ld1) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q   <= pixel_i;
      line1_q <= r_cur[1:0];
      emit1_q <= emit_a;
      meta1_q <= meta_a;
    end
  end

  // Column oldest row first: rotate the stores by the row just overwritten.
  pix_t col [WinSize];

  always_comb begin
    for (int i = 0; i < Lines; i++) begin
      col[i] = line_rd[2'(line1_q + 2'(i))];
    end
    col[WinSize-1] = px1_q;
  end

  // Stage 2: the window cells themselves; shift once per pixel.
  logic                 shift;
  logic                 emit2_q;
  meta_t                meta2_q;
  logic [RowSumW-1:0]   row_sum [WinSize];

  assign shift = ld2 && v1_q;

  gbw_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (shift),
    .kernel_sel_i (ksel_q),
    .col_i        (col),
    .row_sum_o    (row_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ld2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      emit2_q <= emit1_q;
      meta2_q <= meta1_q;
    end
  end

  // Stage 3: row sums; only positions that give a result go on.
  logic [RowSumW-1:0] row_sum3_q [WinSize];
  meta_t              meta3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ld3) begin
      v3_q <= v2_q && emit2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      row_sum3_q <= row_sum;
      meta3_q    <= meta2_q;
    end
  end

  // Stage 4: full weighted sum.
  logic [SumW-1:0] sum4_d, sum4_q;
  meta_t           meta4_q;

  always_comb begin
    sum4_d = '0;
    for (int i = 0; i < WinSize; i++) begin
      sum4_d = sum4_d + SumW'(row_sum3_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ld4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      sum4_q  <= sum4_d;
      meta4_q <= meta3_q;
    end
  end

  // Output stage: divide by 16 as a shift, by 159 through the reciprocal.
  logic [SumW+RecipW-1:0] recip_prod;
  pix_t                   blurred_d, blurred_q;
  meta_t                  meta_o_q;

  assign recip_prod = (SumW + RecipW)'(sum4_q) * (SumW + RecipW)'(Recip159);
  assign blurred_d  = ksel_q ? recip_prod[RecipShift +: PixW] : sum4_q[4 +: PixW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (ldo) begin
      vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ldo) begin
      blurred_q <= blurred_d;
      meta_o_q  <= meta4_q;
    end
  end

  assign out_valid_o = vo_q;
  assign blurred_o   = blurred_q;
  assign column_o    = meta_o_q.cx;
  assign row_o       = meta_o_q.cy;
  assign last_o      = meta_o_q.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_empty_out_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vo_q |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ({1'b0, col_q} < $past(w_eff)))
    else $error("column counter left the frame");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ({1'b0, row_q} < $past(h_eff)))
    else $error("row counter left the frame");

  a_centre_off_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (column_o >= PosW'(3) && row_o >= PosW'(3)))
    else $error("result centre too close to the frame edge");

endmodule
